/* hw/rtl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, kind codes and pipeline tag types of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int COEF_W = 16;
  localparam int FRAC_W = 16;
  localparam int OUT_W  = 34;

  localparam int PROD_W = 2 * COEF_W;
  localparam int D_W    = 2 * COEF_W + 2;
  localparam int MAG_W  = 2 * COEF_W + 1;
  // root bits of |d| * 2^(2*FRAC_W)
  localparam int R_W    = (MAG_W + 2 * FRAC_W + 1) / 2;
  localparam int RAD_W  = 2 * R_W;
  localparam int REM_W  = R_W + 2;
  localparam int BS_W   = COEF_W + FRAC_W + 1;
  localparam int NUM_W  = ((BS_W - 1 > R_W) ? BS_W - 1 : R_W) + 1;
  localparam int DEN_W  = COEF_W + 1;
  localparam int SAT_W  = ((NUM_W > OUT_W) ? NUM_W : OUT_W) + 1;

  typedef enum logic [1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_ONE_REAL = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_DEGEN    = 2'd3
  } root_kind_e;

  typedef struct packed {
    root_kind_e              kind;
    logic signed [BS_W-1:0]  b_scaled;
    logic [DEN_W-1:0]        den;
    logic                    den_neg;
  } sqrt_tag_t;

  typedef struct packed {
    root_kind_e kind;
    logic       neg;
  } div_tag_t;

endpackage

`default_nettype wire

/* hw/rtl/qrs_sqrt.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt
  import qrs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [RAD_W-1:0] rad_i,
  input  wire sqrt_tag_t        tag_i,
  output logic                  valid_o,
  output logic [R_W-1:0]        root_o,
  output sqrt_tag_t             tag_o
);

  logic [R_W:1]       vld_q;
  logic [REM_W-1:0]   rem_q  [1:R_W];
  logic [R_W-1:0]     root_q [1:R_W];
  logic [RAD_W-1:0]   rad_q  [1:R_W];
  sqrt_tag_t          tag_q  [1:R_W];

  logic [REM_W-1:0]   rem_s  [R_W];
  logic [R_W-1:0]     root_s [R_W];
  logic [RAD_W-1:0]   rad_s  [R_W];
  sqrt_tag_t          tag_s  [R_W];

  logic [REM_W-1:0]   cur   [R_W];
  logic [REM_W-1:0]   trial [R_W];

  // stage 0 is the input itself
  always_comb begin
    rem_s[0]  = '0;
    root_s[0] = '0;
    rad_s[0]  = rad_i;
    tag_s[0]  = tag_i;
    for (int i = 1; i < R_W; i++) begin
      rem_s[i]  = rem_q[i];
      root_s[i] = root_q[i];
      rad_s[i]  = rad_q[i];
      tag_s[i]  = tag_q[i];
    end
    for (int i = 0; i < R_W; i++) begin
      cur[i]   = {rem_s[i][REM_W-3:0], rad_s[i][RAD_W-1 -: 2]};
      trial[i] = {root_s[i], 2'b01};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[R_W-1:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < R_W; i++) begin
        if (cur[i] >= trial[i]) begin
          rem_q[i+1]  <= cur[i] - trial[i];
          root_q[i+1] <= {root_s[i][R_W-2:0], 1'b1};
        end else begin
          rem_q[i+1]  <= cur[i];
          root_q[i+1] <= {root_s[i][R_W-2:0], 1'b0};
        end
        rad_q[i+1] <= rad_s[i] << 2;
        tag_q[i+1] <= tag_s[i];
      end
    end
  end

  assign valid_o = vld_q[R_W];
  assign root_o  = root_q[R_W];
  assign tag_o   = tag_q[R_W];

endmodule

`default_nettype wire

/* hw/rtl/qrs_div.sv */
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div
  import qrs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire div_tag_t         tag_i,
  output logic                  valid_o,
  output logic [NUM_W-1:0]      quo_o,
  output div_tag_t              tag_o
);

  logic [NUM_W:1]     vld_q;
  logic [DEN_W-1:0]   rem_q [1:NUM_W];
  logic [NUM_W-1:0]   num_q [1:NUM_W];
  logic [DEN_W-1:0]   den_q [1:NUM_W];
  div_tag_t           tag_q [1:NUM_W];

  logic [DEN_W-1:0]   rem_s [NUM_W];
  logic [NUM_W-1:0]   num_s [NUM_W];
  logic [DEN_W-1:0]   den_s [NUM_W];
  div_tag_t           tag_s [NUM_W];

  logic [DEN_W:0]     cur [NUM_W];
  logic               ge  [NUM_W];

  always_comb begin
    rem_s[0] = '0;
    num_s[0] = num_i;
    den_s[0] = den_i;
    tag_s[0] = tag_i;
    for (int i = 1; i < NUM_W; i++) begin
      rem_s[i] = rem_q[i];
      num_s[i] = num_q[i];
      den_s[i] = den_q[i];
      tag_s[i] = tag_q[i];
    end
    for (int i = 0; i < NUM_W; i++) begin
      cur[i] = {rem_s[i], num_s[i][NUM_W-1]};
      ge[i]  = cur[i] >= {1'b0, den_s[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NUM_W-1:1], valid_i};
    end
  end

  // quotient bits shift in where numerator bits shift out
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_W; i++) begin
        if (ge[i]) begin
          rem_q[i+1] <= DEN_W'(cur[i] - {1'b0, den_s[i]});
        end else begin
          rem_q[i+1] <= cur[i][DEN_W-1:0];
        end
        num_q[i+1] <= {num_s[i][NUM_W-2:0], ge[i]};
        den_q[i+1] <= den_s[i];
        tag_q[i+1] <= tag_s[i];
      end
    end
  end

  assign valid_o = vld_q[NUM_W];
  assign quo_o   = num_q[NUM_W];
  assign tag_o   = tag_q[NUM_W];

endmodule

`default_nettype wire

/* hw/rtl/quadratic_root_solver.sv */
// Pipeline: 2 front stages, 33 square root stages, 1 numerator stage,
//   34 divider stages and 1 output stage.
// Throughput: one coefficient set per cycle; the whole pipeline holds
//   while a result waits on m_axis_tready.
// Reset: rst_ni clears all valid bits at once; no result is pending after it.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Streaming solver for a*x^2 + b*x + c with fixed point roots.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver
  import qrs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // coef_a, coef_b, coef_c
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // root_first, root_second, zero pad
  output logic [1:0]       m_axis_tuser    // root_kind
);

  logic en;

  // front: products
  logic                     v1_q;
  logic signed [COEF_W-1:0] a1_q, b1_q;
  logic signed [PROD_W-1:0] bb_q, ac_q;

  // discriminant
  logic signed [D_W-1:0]    d;
  logic [MAG_W-1:0]         mag;
  logic signed [DEN_W-1:0]  a2;
  sqrt_tag_t                tag2;
  logic                     v2_q;
  logic [MAG_W-1:0]         mag2_q;
  sqrt_tag_t                tag2_q;

  // square root
  logic                     sq_valid;
  logic [R_W-1:0]           sq_root;
  sqrt_tag_t                sq_tag;

  // numerators
  logic signed [NUM_W:0]    bs, sx, n1, n2;
  logic                     v3_q;
  logic [NUM_W-1:0]         n1_q, n2_q;
  logic [DEN_W-1:0]         den3_q;
  div_tag_t                 t1_q, t2_q;

  // dividers
  logic                     dv1_valid, dv2_valid;
  logic [NUM_W-1:0]         q1, q2;
  div_tag_t                 dt1, dt2;

  // output
  logic [OUT_W-1:0]         r1, r2;
  logic                     out_v_q;
  root_kind_e               kind_q;
  logic [OUT_W-1:0]         first_q, second_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= sq_valid;
      out_v_q <= dv1_valid && dv2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q <= $signed(s_axis_tdata[15:0]);
      b1_q <= $signed(s_axis_tdata[31:16]);
      bb_q <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]);
      ac_q <= $signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[47:32]);
    end
  end

  always_comb begin
    d   = D_W'(bb_q) - (D_W'(ac_q) <<< 2);
    mag = d[D_W-1] ? MAG_W'(-d) : MAG_W'(d);
    a2  = DEN_W'(a1_q) <<< 1;
    tag2.den      = a2[DEN_W-1] ? DEN_W'(-a2) : DEN_W'(a2);
    tag2.den_neg  = a1_q[COEF_W-1];
    tag2.b_scaled = -(BS_W'(b1_q) <<< FRAC_W);
    if (a1_q == '0) begin
      tag2.kind = KIND_DEGEN;
    end else if (d == '0) begin
      tag2.kind = KIND_ONE_REAL;
    end else if (d[D_W-1]) begin
      tag2.kind = KIND_COMPLEX;
    end else begin
      tag2.kind = KIND_TWO_REAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag2_q <= mag;
      tag2_q <= tag2;
    end
  end

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   (RAD_W'(mag2_q) << (2 * FRAC_W)),
    .tag_i   (tag2_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  // complex pair divides -b and the root separately
  always_comb begin
    bs = (NUM_W + 1)'(sq_tag.b_scaled);
    sx = $signed({1'b0, (NUM_W)'(sq_root)});
    if (sq_tag.kind == KIND_COMPLEX) begin
      n1 = bs;
      n2 = sx;
    end else begin
      n1 = bs + sx;
      n2 = bs - sx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q      <= n1[NUM_W] ? NUM_W'(-n1) : NUM_W'(n1);
      n2_q      <= n2[NUM_W] ? NUM_W'(-n2) : NUM_W'(n2);
      den3_q    <= sq_tag.den;
      t1_q.kind <= sq_tag.kind;
      t1_q.neg  <= n1[NUM_W] ^ sq_tag.den_neg;
      t2_q.kind <= sq_tag.kind;
      t2_q.neg  <= n2[NUM_W] ^ sq_tag.den_neg;
    end
  end

  qrs_div u_div_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (n1_q),
    .den_i   (den3_q),
    .tag_i   (t1_q),
    .valid_o (dv1_valid),
    .quo_o   (q1),
    .tag_o   (dt1)
  );

  qrs_div u_div_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (n2_q),
    .den_i   (den3_q),
    .tag_i   (t2_q),
    .valid_o (dv2_valid),
    .quo_o   (q2),
    .tag_o   (dt2)
  );

  function automatic logic [OUT_W-1:0] saturate(logic [NUM_W-1:0] q, logic neg);
    logic [SAT_W-1:0] qx;
    logic [SAT_W-1:0] lim;
    logic [OUT_W-1:0] res;
    qx  = SAT_W'(q);
    lim = SAT_W'(1) << (OUT_W - 1);
    if (!neg) begin
      res = (qx >= lim) ? OUT_W'(lim - SAT_W'(1)) : OUT_W'(qx);
    end else begin
      res = (qx > lim) ? OUT_W'(lim) : OUT_W'(-qx);
    end
    return res;
  endfunction

  always_comb begin
    r1 = saturate(q1, dt1.neg);
    r2 = saturate(q2, dt2.neg);
    if (dt1.kind == KIND_DEGEN) begin
      r1 = '0;
      r2 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q   <= dt1.kind;
      first_q  <= r1;
      second_q <= r2;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(72 - 2 * OUT_W)'(0), second_q, first_q};
  assign m_axis_tuser  = kind_q;

endmodule

`default_nettype wire

/* hw/rtl/qrs_checker.sv */
// ----------------------------------------------------------------------------
// qrs_checker
// Port level checks of the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_checker
  import qrs_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [47:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // input side only stalls on a stalled output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_DEGEN |-> m_axis_tdata == '0)
    else $error("degenerate kind with nonzero roots");

  a_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ONE_REAL
      |-> m_axis_tdata[OUT_W-1:0] == m_axis_tdata[2*OUT_W-1:OUT_W])
    else $error("double root fields differ");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* tb/sv/qrs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_scoreboard
// Watches both streams of the quadratic root solver. Each accepted
// coefficient set is solved here in fixed point, and each accepted result
// is compared with the oldest pending solution.
// ----------------------------------------------------------------------------

module qrs_scoreboard
  import qrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o,
  output int          kind_seen_o [4]
);

  typedef struct {
    root_kind_e         kind;
    logic signed [33:0] first;
    logic signed [33:0] second;
  } roots_t;

  roots_t solutions_q[$];
  int     fail_count;
  int     results_seen;
  int     kind_seen [4];

  assign fail_count_o   = fail_count;
  assign pending_o      = solutions_q.size();
  assign results_seen_o = results_seen;
  assign kind_seen_o    = kind_seen;

  // floor(sqrt(mag) * 2^16), digit by digit over mag * 2^32
  function automatic longint unsigned fixed_sqrt(longint unsigned mag);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned trial;
    longint unsigned pair;
    root = 0;
    rem  = 0;
    for (int i = 31 + FRAC_W; i >= 0; i--) begin
      pair = 0;
      if (i >= FRAC_W) pair = (mag >> (2 * (i - FRAC_W))) & 64'd3;
      rem   = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [33:0] clamp34(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< 33) - 1;
    lo = -(longint'(1) <<< 33);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[33:0];
  endfunction

  function automatic roots_t solve_quadratic(logic [47:0] coefs);
    roots_t r;
    longint a;
    longint b;
    longint c;
    longint disc;
    longint den;
    longint num_b;
    longint s;
    a = longint'($signed(coefs[15:0]));
    b = longint'($signed(coefs[31:16]));
    c = longint'($signed(coefs[47:32]));
    if (a == 0) begin
      r.kind   = KIND_DEGEN;
      r.first  = '0;
      r.second = '0;
      return r;
    end
    disc  = b * b - 4 * a * c;
    den   = 2 * a;
    num_b = -b * (longint'(1) <<< FRAC_W);
    if (disc > 0) begin
      s        = longint'(fixed_sqrt(disc));
      r.kind   = KIND_TWO_REAL;
      r.first  = clamp34((num_b + s) / den);
      r.second = clamp34((num_b - s) / den);
    end else if (disc == 0) begin
      r.kind   = KIND_ONE_REAL;
      r.first  = clamp34(num_b / den);
      r.second = r.first;
    end else begin
      s        = longint'(fixed_sqrt(-disc));
      r.kind   = KIND_COMPLEX;
      r.first  = clamp34(num_b / den);
      r.second = clamp34(s / den);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    roots_t want;
    if (!rst_ni) begin
      solutions_q.delete();
      fail_count   <= 0;
      results_seen <= 0;
      for (int k = 0; k < 4; k++) kind_seen[k] <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        solutions_q.push_back(solve_quadratic(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        kind_seen[m_axis_tuser] <= kind_seen[m_axis_tuser] + 1;
        if (solutions_q.size() == 0) begin
          report_mismatch("result transaction with nothing pending");
        end else begin
          want = solutions_q.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", m_axis_tuser, want.kind));
          if (m_axis_tdata[33:0] !== want.first)
            report_mismatch($sformatf("first got %0d want %0d",
                                      $signed(m_axis_tdata[33:0]), want.first));
          if (m_axis_tdata[67:34] !== want.second)
            report_mismatch($sformatf("second got %0d want %0d",
                                      $signed(m_axis_tdata[67:34]), want.second));
          if (m_axis_tdata[71:68] !== 4'd0)
            report_mismatch("nonzero pad bits");
        end
      end
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives coefficient sets into the quadratic root solver with random gaps
// and output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------

module testbench;
  import qrs_pkg::*;

  localparam int LATENCY     = 71;
  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int fail_count;
  int pending;
  int results_seen;
  int kind_seen [4];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  int sets_sent = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  quadratic_root_solver uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  qrs_scoreboard checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending),
    .results_seen_o(results_seen), .kind_seen_o(kind_seen)
  );

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // no-progress watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else if (rst_ni && ++quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("quadratic_root_solver test failed");
      $finish;
    end
  end

  // valid stays high between back to back transactions
  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    sets_sent++;
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(16)) - 8);
      3: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // random set that is sometimes built as a perfect square or with a zero a
  task automatic send_random_set();
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] r;
    int sel;
    a = pick_coef();
    b = pick_coef();
    sel = $urandom_range(9);
    if (sel < 2) begin
      // perfect square: c = b^2/(4a) with b = 2*a*r
      r = 16'($signed($urandom_range(6)) - 3);
      a = 16'($signed($urandom_range(60)) - 30);
      b = 16'(2 * $signed(a) * $signed(r));
      send_coefs(a, b, 16'($signed(a) * $signed(r) * $signed(r)));
    end else if (sel < 3) begin
      send_coefs(16'd0, b, pick_coef());
    end else begin
      send_coefs(a, b, pick_coef());
    end
  endtask

  task automatic run_phase(int sender_pct, int receiver_pct, int count);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int i = 0; i < count; i++) send_random_set();
  endtask

  initial begin
    int drain;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, zero a, double root, complex, two real
    send_coefs(16'h0000, 16'h1234, 16'h5678);
    send_coefs(16'h0000, 16'h0000, 16'h0000);
    send_coefs(16'h0001, 16'h0000, 16'h0000);
    send_coefs(16'h0001, 16'hfffc, 16'h0004);
    send_coefs(16'hffff, 16'h0004, 16'hfffc);
    send_coefs(16'h0001, 16'h0000, 16'h0001);
    send_coefs(16'hffff, 16'h0000, 16'hffff);
    send_coefs(16'h0001, 16'h0000, 16'hffff);
    send_coefs(16'h0001, 16'h8000, 16'h8000);
    send_coefs(16'h0001, 16'h8000, 16'h7fff);
    send_coefs(16'h8000, 16'h8000, 16'h7fff);
    send_coefs(16'h8000, 16'h7fff, 16'h8000);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h0000, 16'h8000);
    send_coefs(16'hffff, 16'h7fff, 16'h0000);
    send_coefs(16'h0001, 16'h7fff, 16'h0000);
    send_coefs(16'hffff, 16'h8000, 16'h0000);
    send_coefs(16'h0002, 16'h0003, 16'h0001);
    send_coefs(16'haaaa, 16'h5555, 16'haaaa);
    send_coefs(16'h5555, 16'haaaa, 16'h5555);

    // hold off until the pipeline has drained
    s_axis_tvalid <= 1'b0;
    recv_idle_pct = 30;
    while (pending != 0) @(posedge clk_i);

    run_phase(22, 74, 580);
    run_phase(74, 22, 580);
    run_phase(0, 0, 590);

    s_axis_tvalid <= 1'b0;
    recv_idle_pct = 0;
    while (pending != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 2 * LATENCY) begin
      @(posedge clk_i);
      drain++;
    end

    $display("sent %0d coefficient sets, checked %0d results", sets_sent, results_seen);
    $display("kinds: two real %0d, one real %0d, complex %0d, a zero %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (fail_count == 0 && pending == 0)
      $display("quadratic_root_solver test passed");
    else
      $display("quadratic_root_solver test failed");
    $finish;
  end

endmodule
